@@ design/octe_pkg.sv @@
// ----------------------------------------------------------------------------
// octe_pkg
// Types and constants shared by the object column tile emitter.
// ----------------------------------------------------------------------------
package octe_pkg;

  localparam int VramBytes  = 8192;
  localparam int StoreHalf  = VramBytes / 2;
  localparam int HalfAw     = $clog2(StoreHalf);
  localparam int ObjEntries = 192;

  // Item kinds
  localparam logic [1:0] KindWrite = 2'd0;
  localparam logic [1:0] KindEntry = 2'd1;
  localparam logic [1:0] KindFrame = 2'd2;

  // Configuration register indexes
  localparam logic RegCharBank = 1'b0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] vram_addr;
    logic [7:0]  vram_data;
    logic [8:0]  entry_index;
    logic [7:0]  obj_y;
    logic [7:0]  obj_num;
    logic [7:0]  obj_x;
    logic [7:0]  obj_attr;
  } in_item_t;

  typedef struct packed {
    logic [12:0] tile_code;
    logic [3:0]  tile_color;
    logic        flip_x;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        last;
  } out_item_t;

  // Write side of the split video store (even and odd byte banks)
  typedef struct packed {
    logic              we;
    logic              odd;
    logic [HalfAw-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // Read side: both banks read the same pair address
  typedef struct packed {
    logic              re;
    logic [HalfAw-1:0] addr;
  } store_rd_t;

endpackage

@@ design/octe_if.sv @@
// ----------------------------------------------------------------------------
// octe_if
// Valid/ready channels for input items and tile result items.
// ----------------------------------------------------------------------------
interface octe_in_if;
  logic               valid;
  logic               ready;
  octe_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface octe_out_if;
  logic                valid;
  logic                ready;
  octe_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/object_column_tile_emitter_unit.sv @@
// ----------------------------------------------------------------------------
// object_column_tile_emitter_unit
// Object-list tile emitter: video store, entry expansion into 8x8 tiles.
// ----------------------------------------------------------------------------
// A write item stores one byte and a frame-start item clears the running
// column x. An object entry that is used and not empty expands into 4 tiles
// (sprite) or 64 tiles (column), one tile read per cycle when the output is
// not stalled. Reads start the cycle after the entry is taken, and the input
// is held off until the last read has issued; the last tile shows once that
// read has passed the pending and output registers. An output stall holds
// both the reads and the input. The rate is set by the video store read
// port: the store is split into an even and an odd byte bank of 4096 bytes
// each, and every tile reads one byte pair from them.
// Store contents are undefined until written; there is no clearing pass.
module object_column_tile_emitter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  octe_in_if.sink     in_if,
  octe_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import octe_pkg::*;

  logic      char_bank;
  store_wr_t wr;
  store_rd_t rd;
  logic [7:0] rdata_even;
  logic [7:0] rdata_odd;

  octe_apb u_apb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .char_bank_o (char_bank)
  );

  octe_ram #(
    .WIDTH (8),
    .DEPTH (4096)
  ) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (wr.we && !wr.odd),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd.re),
    .raddr_i (rd.addr),
    .rdata_o (rdata_even)
  );

  octe_ram #(
    .WIDTH (8),
    .DEPTH (4096)
  ) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (wr.we && wr.odd),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd.re),
    .raddr_i (rd.addr),
    .rdata_o (rdata_odd)
  );

  octe_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_bank_i  (char_bank),
    .in_if        (in_if),
    .out_if       (out_if),
    .wr_o         (wr),
    .rd_o         (rd),
    .rdata_even_i (rdata_even),
    .rdata_odd_i  (rdata_odd)
  );

endmodule

@@ design/octe_ram.sv @@
// ----------------------------------------------------------------------------
// octe_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module octe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/octe_apb.sv @@
// ----------------------------------------------------------------------------
// octe_apb
// APB-style configuration register file (character bank bit).
// ----------------------------------------------------------------------------
module octe_apb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        char_bank_o
);
  import octe_pkg::*;

  logic char_bank_q, char_bank_d;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_comb begin
    char_bank_d = char_bank_q;
    if (psel && penable && pwrite && (reg_idx == RegCharBank)) begin
      char_bank_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_bank_q <= 1'b0;
    end else begin
      char_bank_q <= char_bank_d;
    end
  end

  always_comb begin
    case (reg_idx)
      RegCharBank: prdata = {31'd0, char_bank_q};
      default:     prdata = 32'd0;
    endcase
  end

  assign char_bank_o = char_bank_q;

endmodule

@@ design/octe_seq.sv @@
// ----------------------------------------------------------------------------
// octe_seq
// Entry decode, tile address sequencer and store read/result pipeline.
// ----------------------------------------------------------------------------
module octe_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             char_bank_i,
  octe_in_if.sink                          in_if,
  octe_out_if.source                       out_if,
  output octe_pkg::store_wr_t              wr_o,
  output octe_pkg::store_rd_t              rd_o,
  input  logic [7:0]                       rdata_even_i,
  input  logic [7:0]                       rdata_odd_i
);
  import octe_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  localparam logic [10:0] UsedLim = 11'(ObjEntries);
  localparam logic [10:0] AltLo   = 11'(ObjEntries + 'h60);
  localparam logic [10:0] AltHi   = 11'(ObjEntries + 'h70);

  logic              state_q;
  logic [7:0]        column_x_q;
  logic              col_q;
  logic [HalfAw-1:0] base_q;
  logic [7:0]        sy_q;
  logic              attr_q;
  logic              xc_q;
  logic [4:0]        yc_q;

  // item in flight at the store read port
  logic              pend_q;
  logic [7:0]        pend_x_q;
  logic [7:0]        pend_y_q;
  logic              pend_last_q;
  logic              pend_attr_q;

  logic              out_valid_q;
  out_item_t         out_q;

  logic              in_acc;
  logic [10:0]       idx_w;
  logic              idx_used;
  logic              entry_empty;
  logic              start_entry;
  logic              load;
  logic              issue;
  logic              tile_last;
  logic [HalfAw-1:0] base_d;
  logic [7:0]        num;

  assign in_if.ready = (state_q == StIdle);
  assign in_acc      = in_if.valid && in_if.ready;
  assign num         = in_if.data.obj_num;

  assign idx_w    = {2'b00, in_if.data.entry_index};
  assign idx_used = (idx_w < UsedLim) || ((idx_w >= AltLo) && (idx_w < AltHi));
  assign entry_empty = (in_if.data.obj_y | num | in_if.data.obj_x
                        | in_if.data.obj_attr) == 8'd0;
  assign start_entry = in_acc && (in_if.data.kind == KindEntry) && idx_used
                       && !entry_empty;

  // base in byte pairs; sprite base adds the type offset and the 12-byte skip
  always_comb begin
    if (num[7]) begin
      base_d = {num[5:0], 6'd0};
    end else begin
      base_d = HalfAw'({1'b0, num[4:0], 6'd0}) + HalfAw'({num[6:5], 3'd0})
               + HalfAw'(6);
    end
  end

  assign wr_o.we   = in_acc && (in_if.data.kind == KindWrite);
  assign wr_o.odd  = in_if.data.vram_addr[0];
  assign wr_o.addr = in_if.data.vram_addr[12:1];
  assign wr_o.data = in_if.data.vram_data;

  assign tile_last = xc_q && (yc_q == (col_q ? 5'd31 : 5'd1));
  assign load      = pend_q && (!out_valid_q || out_if.ready);
  assign issue     = (state_q == StRun) && (!pend_q || load);

  assign rd_o.re   = issue;
  assign rd_o.addr = base_q + HalfAw'({xc_q, 5'd0}) + HalfAw'(yc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      column_x_q  <= 8'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      xc_q        <= 1'b0;
      yc_q        <= 5'd0;
    end else begin
      if (in_acc && (in_if.data.kind == KindFrame)) begin
        column_x_q <= 8'd0;
      end
      if (start_entry) begin
        state_q <= StRun;
        xc_q    <= 1'b0;
        yc_q    <= 5'd0;
        if (num[7:6] == 2'b11) begin
          column_x_q <= column_x_q + 8'd16;
        end else begin
          column_x_q <= in_if.data.obj_x;
        end
      end
      if (issue) begin
        pend_q <= 1'b1;
        if (tile_last) begin
          state_q <= StIdle;
        end
        // column-major: walk down the left column, then the right one
        if (yc_q == (col_q ? 5'd31 : 5'd1)) begin
          yc_q <= 5'd0;
          xc_q <= 1'b1;
        end else begin
          yc_q <= yc_q + 5'd1;
        end
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_entry) begin
      col_q  <= num[7];
      base_q <= base_d;
      sy_q   <= num[7] ? (8'd0 - in_if.data.obj_y) : (8'd240 - in_if.data.obj_y);
      attr_q <= in_if.data.obj_attr[1];
    end
    if (issue) begin
      pend_x_q    <= column_x_q + {4'd0, xc_q, 3'd0};
      pend_y_q    <= sy_q + {yc_q, 3'd0};
      pend_last_q <= tile_last;
      pend_attr_q <= attr_q;
    end
    if (load) begin
      out_q.tile_code  <= {char_bank_i, rdata_odd_i[7], rdata_odd_i[2:0], rdata_even_i};
      out_q.tile_color <= {pend_attr_q, rdata_odd_i[5:3]};
      out_q.flip_x     <= rdata_odd_i[6];
      out_q.pos_x      <= pend_x_q;
      out_q.pos_y      <= pend_y_q;
      out_q.last       <= pend_last_q;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

endmodule
